[rtl/core/bz2x_pkg.sv]
// Shared constants, types and helper functions for the 2x bilinear zoom block.
`timescale 1ns / 1ps
`default_nettype none
package bz2x_pkg;

  localparam int unsigned MAX_COLS  = 1024;
  localparam int unsigned MAX_ROWS  = 1024;
  localparam int unsigned CW        = $clog2(MAX_COLS);
  localparam int unsigned RW        = $clog2(MAX_ROWS);
  localparam int unsigned CLIM_W    = CW + 1;
  localparam int unsigned RLIM_W    = RW + 1;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIM_RST   = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IN_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IN_ROWS = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_DIAG,
    PH_VERT,
    PH_HORZ,
    PH_OWN
  } bz2x_phase_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] lf;
    logic [PIX_W-1:0] ul;
    logic [RW-1:0]    row;
    logic [CW-1:0]    col;
  } bz2x_item_t;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned x;
    x = 32'(v);
    if (x == 0) begin
      return 1;
    end
    if (x > maxv) begin
      return maxv;
    end
    return x;
  endfunction

  function automatic logic [COORD_W-1:0] dbl_coord(input logic [31:0] x,
                                                   input logic odd);
    logic [31:0] t;
    t = {x[30:0], 1'b0} - 32'(odd);
    return t[COORD_W-1:0];
  endfunction

  localparam logic [CLIM_W-1:0] COLS_RST = CLIM_W'(clamp_dim(CFG_W'(DIM_RST), MAX_COLS));
  localparam logic [RLIM_W-1:0] ROWS_RST = RLIM_W'(clamp_dim(CFG_W'(DIM_RST), MAX_ROWS));

endpackage
`default_nettype wire

[rtl/core/bz2x_fetch.sv]
// Input stage: position counters, line buffer and the held source pixel.
`timescale 1ns / 1ps
`default_nettype none
module bz2x_fetch
  import bz2x_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PIX_W-1:0]  in_pixel,
  input  wire logic [CLIM_W-1:0] cols_lim,
  input  wire logic [RLIM_W-1:0] rows_lim,
  input  wire logic              restart,
  output logic                   item_valid,
  output bz2x_item_t             item,
  input  wire logic              item_take
);

  logic [PIX_W-1:0] mem [MAX_COLS];

  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]    row_cnt_r, row_cnt_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic [PIX_W-1:0] rd_r;
  logic             byp_r;
  logic [PIX_W-1:0] byp_d_r;
  logic [PIX_W-1:0] left_r;
  logic [PIX_W-1:0] ul_r;
  logic [PIX_W-1:0] up;
  logic             acc;
  logic             adv;
  logic             col_end;
  logic             row_end;

  assign adv      = s1_v_r & item_take;
  assign in_stall = s1_v_r & ~item_take;
  assign acc      = in_valid & ~in_stall;
  assign up       = byp_r ? byp_d_r : rd_r;

  assign col_end = (CLIM_W'(col_cnt_r) + CLIM_W'(1)) == cols_lim;
  assign row_end = (RLIM_W'(row_cnt_r) + RLIM_W'(1)) == rows_lim;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (restart) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (acc) begin
      if (col_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_end ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      s1_v_r    <= 1'b0;
      left_r    <= '0;
      ul_r      <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      s1_v_r    <= s1_v_nxt;
      if (adv) begin
        left_r <= s1_pix_r;
        ul_r   <= up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r <= in_pixel;
      s1_col_r <= col_cnt_r;
      s1_row_r <= row_cnt_r;
      rd_r     <= mem[col_cnt_r];
      byp_r    <= adv && (s1_col_r == col_cnt_r);
      byp_d_r  <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mem[s1_col_r] <= s1_pix_r;
    end
  end

  assign item_valid = s1_v_r;
  assign item.pix   = s1_pix_r;
  assign item.up    = up;
  assign item.lf    = left_r;
  assign item.ul    = ul_r;
  assign item.row   = s1_row_r;
  assign item.col   = s1_col_r;

endmodule
`default_nettype wire

[rtl/core/bz2x_interp.sv]
// Result stage: averages, coordinates and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bz2x_interp
  import bz2x_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  input  wire bz2x_item_t          item,
  output logic                     item_take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [COORD_W-1:0]       out_row,
  output logic [COORD_W-1:0]       out_col,
  output logic [PIX_W-1:0]         out_value,
  output logic                     out_last
);

  bz2x_phase_t      ph_r, ph_nxt, ph_start;
  logic             s2_v_r, s2_v_nxt;
  logic             hc_r;
  logic [PIX_W-1:0] vd_r, vv_r, vh_r, vp_r;
  logic [COORD_W-1:0] re_r, ro_r, ce_r, co_r;
  logic [PIX_W+1:0] sum4;
  logic [PIX_W:0]   sumv, sumh;
  logic             hr, hc;
  logic             out_acc;
  logic             load;

  assign hr   = item.row != '0;
  assign hc   = item.col != '0;
  assign sum4 = (PIX_W+2)'(item.ul) + (PIX_W+2)'(item.up) + (PIX_W+2)'(item.lf)
              + (PIX_W+2)'(item.pix) + (PIX_W+2)'(2);
  assign sumv = (PIX_W+1)'(item.up) + (PIX_W+1)'(item.pix) + (PIX_W+1)'(1);
  assign sumh = (PIX_W+1)'(item.lf) + (PIX_W+1)'(item.pix) + (PIX_W+1)'(1);

  assign out_acc   = s2_v_r & ~out_stall;
  assign out_last  = ph_r == PH_OWN;
  assign item_take = ~s2_v_r | (out_acc & out_last);
  assign load      = item_take & item_valid;

  always_comb begin
    if (hr && hc) begin
      ph_start = PH_DIAG;
    end else if (hr) begin
      ph_start = PH_VERT;
    end else if (hc) begin
      ph_start = PH_HORZ;
    end else begin
      ph_start = PH_OWN;
    end
  end

  always_comb begin
    ph_nxt   = ph_r;
    s2_v_nxt = s2_v_r;
    if (item_take) begin
      s2_v_nxt = item_valid;
      if (item_valid) begin
        ph_nxt = ph_start;
      end
    end else if (out_acc) begin
      unique case (ph_r)
        PH_DIAG: ph_nxt = PH_VERT;
        PH_VERT: ph_nxt = hc_r ? PH_HORZ : PH_OWN;
        PH_HORZ: ph_nxt = PH_OWN;
        PH_OWN:  ph_nxt = PH_OWN;
        default: ph_nxt = PH_OWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      ph_r   <= PH_OWN;
    end else begin
      s2_v_r <= s2_v_nxt;
      ph_r   <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hc_r <= hc;
      vd_r <= sum4[PIX_W+1:2];
      vv_r <= sumv[PIX_W:1];
      vh_r <= sumh[PIX_W:1];
      vp_r <= item.pix;
      re_r <= dbl_coord(32'(item.row), 1'b0);
      ro_r <= dbl_coord(32'(item.row), 1'b1);
      ce_r <= dbl_coord(32'(item.col), 1'b0);
      co_r <= dbl_coord(32'(item.col), 1'b1);
    end
  end

  always_comb begin
    unique case (ph_r)
      PH_DIAG: begin
        out_value = vd_r;
        out_row   = ro_r;
        out_col   = co_r;
      end
      PH_VERT: begin
        out_value = vv_r;
        out_row   = ro_r;
        out_col   = ce_r;
      end
      PH_HORZ: begin
        out_value = vh_r;
        out_row   = re_r;
        out_col   = co_r;
      end
      default: begin
        out_value = vp_r;
        out_row   = re_r;
        out_col   = ce_r;
      end
    endcase
  end

  assign out_valid = s2_v_r;

endmodule
`default_nettype wire

[rtl/core/bilinear_zoom_2x_top.sv]
// Top level of the streaming 2x bilinear zoom block.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | in_pixel
//   out     | out_valid/out_stall | out_row, out_col, out_value, out_last
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One result leaves per cycle while out_stall is low, so a source pixel gives
// 1, 2 or 4 results at the output port (4 in the image interior); the pixel is
// registered in the input stage and then in the result stage before its first
// result is presented. The line buffer is a single-port-write, registered-read
// memory of MAX_COLS bytes; no clearing pass is run.
// Reset zeroes the position and neighbour pixels and empties both stages.
// A stall on the output holds the result stage and then the input stage.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_zoom_2x_top
  import bz2x_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     in_pixel,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [COORD_W-1:0]        out_row,
  output logic [COORD_W-1:0]        out_col,
  output logic [PIX_W-1:0]          out_value,
  output logic                      out_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CLIM_W-1:0] cols_lim_r;
  logic [RLIM_W-1:0] rows_lim_r;
  logic              cfg_wr;
  logic              restart;
  logic              item_valid;
  bz2x_item_t        item;
  logic              item_take;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign restart   = cfg_wr & ((cfg_index == REG_IN_COLS) | (cfg_index == REG_IN_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_lim_r <= COLS_RST;
      rows_lim_r <= ROWS_RST;
    end else if (cfg_wr) begin
      if (cfg_index == REG_IN_COLS) begin
        cols_lim_r <= CLIM_W'(clamp_dim(cfg_data, MAX_COLS));
      end
      if (cfg_index == REG_IN_ROWS) begin
        rows_lim_r <= RLIM_W'(clamp_dim(cfg_data, MAX_ROWS));
      end
    end
  end

  bz2x_fetch u_fetch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel   (in_pixel),
    .cols_lim   (cols_lim_r),
    .rows_lim   (rows_lim_r),
    .restart    (restart),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  bz2x_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_last)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid)
    else $error("input stalled with an empty input stage");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("transaction sequence broken before its last result");

  a_own_even: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_row[0] == 1'b0 && out_col[0] == 1'b0))
    else $error("final result not on an even row and column");

  a_take_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !item_take)
    else $error("result stage reloaded mid-sequence");

endmodule
`default_nettype wire
